// ===== hdl/http_chunked_body_decoder_assert.svh =====
// Assertion macros for the chunked body decoder, empty under synthesis.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define HCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define HCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HCD_ASSERT_NOW(lbl, ante, cons, msg)
`define HCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/hcd_pkg.sv =====
// Types, constants and helpers shared by the chunked body decoder.
`timescale 1ns / 1ps
package hcd_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 80;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned BODY_W         = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNKED_MODE = 1'b0,
    CFG_BODY_LENGTH  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_SEP1  = 3'd2,
    PH_SEP2  = 3'd3,
    PH_TRAIL = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    HX_WS   = 3'd0,
    HX_ZERO = 3'd1,
    HX_PFX  = 3'd2,
    HX_DIG  = 3'd3,
    HX_STOP = 3'd4
  } hex_e;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_DONE  = 3'd1,
    ST_LINE  = 3'd2,
    ST_CHUNK = 3'd3,
    ST_SEP   = 3'd4,
    ST_BODY  = 3'd5
  } status_e;

  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT   = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF   = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_UX   = 8'h58;
  localparam logic [BYTE_W-1:0] CH_LX   = 8'h78;

  // Result of one chunked-mode step, handed from the parser to the top level.
  typedef struct packed {
    logic    pass;
    status_e status;
  } chk_res_t;

  // One output transfer.
  typedef struct packed {
    status_e           status;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
  } res_t;

  // Hex digit value; bit 4 set marks a non-hex character.
  function automatic logic [4:0] hex_value(logic [BYTE_W-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

  function automatic logic is_space(logic [BYTE_W-1:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

endpackage

// ===== hdl/hcd_chunk_fsm.sv =====
// Chunked transfer parser: size lines, chunk data, separators and trailers.
`timescale 1ns / 1ps
module hcd_chunk_fsm #(
  parameter int unsigned LINE_LIMIT = hcd_pkg::LINE_LIMIT_DEF,
  parameter int unsigned COUNT_BITS = hcd_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      end_i,
  input  logic [hcd_pkg::BYTE_W-1:0] byte_i,
  output hcd_pkg::chk_res_t          res_o
);

  localparam int unsigned LC_W = $clog2(LINE_LIMIT);
  localparam logic [LC_W-1:0] LC_LAST = LC_W'(LINE_LIMIT - 1);

  hcd_pkg::phase_e         phase_q, phase_d;
  hcd_pkg::hex_e           hex_q, hex_d;
  logic [COUNT_BITS-1:0]   chunk_q, chunk_d;
  logic [LC_W-1:0]         lc_q, lc_d;
  logic                    fwc_q, fwc_d;

  logic [LC_W-1:0]         lc_inc;
  logic                    lc_full;
  logic [4:0]              dig;
  logic                    is_hex;
  logic                    is_lf;
  logic                    is_cr;
  logic [COUNT_BITS-1:0]   chunk_dig;
  logic [COUNT_BITS-1:0]   chunk_dec;

  assign lc_inc  = lc_q + LC_W'(1);
  assign lc_full = lc_inc >= LC_LAST;
  assign dig     = hcd_pkg::hex_value(byte_i);
  assign is_hex  = !dig[4];
  assign is_lf   = byte_i == hcd_pkg::CH_LF;
  assign is_cr   = byte_i == hcd_pkg::CH_CR;
  assign chunk_dec = (chunk_q != '0) ? chunk_q - COUNT_BITS'(1) : chunk_q;

  // saturate once a nonzero top nibble would shift out
  assign chunk_dig = (chunk_q[COUNT_BITS-1 -: 4] != 4'h0) ? '1
                   : {chunk_q[COUNT_BITS-5:0], dig[3:0]};

  always_comb begin
    phase_d = phase_q;
    hex_d   = hex_q;
    chunk_d = chunk_q;
    lc_d    = lc_q;
    fwc_d   = fwc_q;
    if (step_i && !end_i) begin
      unique case (phase_q)
        hcd_pkg::PH_SIZE: begin
          if (is_lf) begin
            if (chunk_q == '0) begin
              phase_d = hcd_pkg::PH_TRAIL;
              lc_d    = '0;
              fwc_d   = 1'b0;
            end else begin
              phase_d = hcd_pkg::PH_DATA;
            end
          end else begin
            lc_d = lc_inc;
            if (!lc_full) begin
              unique case (hex_q)
                hcd_pkg::HX_WS: begin
                  if (hcd_pkg::is_space(byte_i)) begin
                    hex_d = hex_q;
                  end else if (byte_i == hcd_pkg::CH_ZERO) begin
                    chunk_d = '0;
                    hex_d   = hcd_pkg::HX_ZERO;
                  end else if (is_hex) begin
                    chunk_d = chunk_dig;
                    hex_d   = hcd_pkg::HX_DIG;
                  end else begin
                    hex_d = hcd_pkg::HX_STOP;
                  end
                end
                hcd_pkg::HX_ZERO: begin
                  if (byte_i == hcd_pkg::CH_LX || byte_i == hcd_pkg::CH_UX) begin
                    hex_d = hcd_pkg::HX_PFX;
                  end else if (is_hex) begin
                    chunk_d = chunk_dig;
                    hex_d   = hcd_pkg::HX_DIG;
                  end else begin
                    hex_d = hcd_pkg::HX_STOP;
                  end
                end
                hcd_pkg::HX_PFX, hcd_pkg::HX_DIG: begin
                  if (is_hex) begin
                    chunk_d = chunk_dig;
                    hex_d   = hcd_pkg::HX_DIG;
                  end else begin
                    hex_d = hcd_pkg::HX_STOP;
                  end
                end
                default: begin
                  hex_d = hex_q;
                end
              endcase
            end
          end
        end
        hcd_pkg::PH_DATA: begin
          chunk_d = chunk_dec;
          if (chunk_dec == '0) begin
            phase_d = hcd_pkg::PH_SEP1;
          end
        end
        hcd_pkg::PH_SEP1: begin
          fwc_d   = is_cr;
          phase_d = hcd_pkg::PH_SEP2;
        end
        hcd_pkg::PH_SEP2: begin
          if (fwc_q && is_lf) begin
            phase_d = hcd_pkg::PH_SIZE;
            lc_d    = '0;
            hex_d   = hcd_pkg::HX_WS;
            chunk_d = '0;
          end
        end
        hcd_pkg::PH_TRAIL: begin
          if (is_lf) begin
            lc_d  = '0;
            fwc_d = 1'b0;
          end else begin
            if (lc_q == '0) begin
              fwc_d = is_cr;
            end
            lc_d = lc_inc;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    res_o.pass   = 1'b0;
    res_o.status = hcd_pkg::ST_RUN;
    if (step_i) begin
      if (end_i) begin
        unique case (phase_q)
          hcd_pkg::PH_SIZE:                  res_o.status = hcd_pkg::ST_LINE;
          hcd_pkg::PH_DATA:                  res_o.status = hcd_pkg::ST_CHUNK;
          hcd_pkg::PH_SEP1, hcd_pkg::PH_SEP2: res_o.status = hcd_pkg::ST_SEP;
          default:                           res_o.status = hcd_pkg::ST_DONE;
        endcase
      end else begin
        unique case (phase_q)
          hcd_pkg::PH_SIZE: begin
            if (!is_lf && lc_full) begin
              res_o.status = hcd_pkg::ST_LINE;
            end
          end
          hcd_pkg::PH_DATA: begin
            res_o.pass = 1'b1;
          end
          hcd_pkg::PH_SEP1: begin
            res_o.status = hcd_pkg::ST_RUN;
          end
          hcd_pkg::PH_SEP2: begin
            if (!(fwc_q && is_lf)) begin
              res_o.status = hcd_pkg::ST_SEP;
            end
          end
          default: begin
            if (is_lf) begin
              if (lc_q == '0 || (lc_q == LC_W'(1) && fwc_q)) begin
                res_o.status = hcd_pkg::ST_DONE;
              end
            end else if (lc_full) begin
              res_o.status = hcd_pkg::ST_DONE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hcd_pkg::PH_SIZE;
      hex_q   <= hcd_pkg::HX_WS;
      chunk_q <= '0;
      lc_q    <= '0;
      fwc_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      chunk_q <= chunk_d;
      lc_q    <= lc_d;
      fwc_q   <= fwc_d;
    end
  end

endmodule

// ===== hdl/http_chunked_body_decoder.sv =====
// Top level of the HTTP response body decoder: stream ports, plain mode, output skid.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_assert.svh"
// Usage:
//   Slave stream: one raw body byte per transfer in s_axis_tdata; s_axis_tuser set
//   marks connection close and the byte is then ignored.
//   Master stream: exactly one transfer per input transfer, in order. tdata holds
//   the payload byte (zero when not a body byte), tuser the payload valid flag and
//   the sticky status (running, complete, bad size line, chunk incomplete, bad
//   separator, body incomplete).
//   Config: cfg_we_i writes register cfg_idx_i (0 chunked mode, 1 body length)
//   with cfg_data_i; write only while the block is idle.
//   Each result is registered in the output register or the skid entry; one byte is
//   taken every cycle while s_axis_tready is high.
//   Reset clears the parser, the byte count, the registers and the status.
//   When the receiver stalls, the output register and one skid entry hold
//   results; s_axis_tready falls once the skid entry is full.
//   Once the status leaves running, inputs are taken and produce no payload.
module http_chunked_body_decoder #(
  parameter int unsigned LINE_LIMIT = hcd_pkg::LINE_LIMIT_DEF,
  parameter int unsigned COUNT_BITS = hcd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // data_byte
  input  logic                          s_axis_tuser,  // stream_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // payload_byte
  output logic [3:0]                    m_axis_tuser,  // status[2:0], payload_valid
  input  logic                          cfg_we_i,
  input  logic [hcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hcd_pkg::BODY_W-1:0]    cfg_data_i
);

  logic                        chunked_q;
  logic [hcd_pkg::BODY_W-1:0]  body_len_q;
  logic [hcd_pkg::BODY_W-1:0]  bp_q, bp_d, bp_inc;
  hcd_pkg::status_e            status_q, status_d;

  hcd_pkg::res_t               res, out_q, skid_q;
  logic                        out_v_q, skid_v_q;
  logic                        in_fire, running, chk_step;
  hcd_pkg::chk_res_t           chk;

  assign s_axis_tready = !skid_v_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign running       = status_q == hcd_pkg::ST_RUN;
  assign chk_step      = in_fire && running && chunked_q;
  assign bp_inc        = bp_q + hcd_pkg::BODY_W'(1);

  hcd_chunk_fsm #(
    .LINE_LIMIT(LINE_LIMIT),
    .COUNT_BITS(COUNT_BITS)
  ) u_chunk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (chk_step),
    .end_i  (s_axis_tuser),
    .byte_i (s_axis_tdata),
    .res_o  (chk)
  );

  always_comb begin
    res.payload_valid = 1'b0;
    status_d          = status_q;
    bp_d              = bp_q;
    if (in_fire && running) begin
      if (chunked_q) begin
        res.payload_valid = chk.pass;
        status_d          = chk.status;
      end else if (body_len_q != '0) begin
        if (s_axis_tuser) begin
          status_d = (bp_q >= body_len_q) ? hcd_pkg::ST_DONE : hcd_pkg::ST_BODY;
        end else if (bp_q >= body_len_q) begin
          status_d = hcd_pkg::ST_DONE;
        end else begin
          res.payload_valid = 1'b1;
          bp_d              = bp_inc;
          if (bp_inc == body_len_q) begin
            status_d = hcd_pkg::ST_DONE;
          end
        end
      end else begin
        if (s_axis_tuser) begin
          status_d = hcd_pkg::ST_DONE;
        end else begin
          res.payload_valid = 1'b1;
          if (bp_q != '1) begin
            bp_d = bp_inc;
          end
        end
      end
    end
    res.payload_byte = res.payload_valid ? s_axis_tdata : '0;
    res.status       = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_q  <= 1'b0;
      body_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (hcd_pkg::cfg_idx_e'(cfg_idx_i))
        hcd_pkg::CFG_CHUNKED_MODE: chunked_q  <= cfg_data_i[0];
        hcd_pkg::CFG_BODY_LENGTH:  body_len_q <= cfg_data_i;
        default:                   chunked_q  <= chunked_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= hcd_pkg::ST_RUN;
      bp_q     <= '0;
    end else begin
      status_q <= status_d;
      bp_q     <= bp_d;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.payload_byte;
  assign m_axis_tuser  = {out_q.status, out_q.payload_valid};

  `HCD_ASSERT_NEXT(a_status_sticky, status_q != hcd_pkg::ST_RUN,
    status_q == $past(status_q), "status left a final value")
  `HCD_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q,
    "skid entry holds a result while the output register is empty")
  `HCD_ASSERT_NOW(a_no_payload_after_end, in_fire && !running,
    !res.payload_valid && res.status == status_q, "payload produced after the body ended")
  `HCD_ASSERT_NEXT(a_count_only_plain, in_fire && chunked_q,
    bp_q == $past(bp_q), "plain byte count moved in chunked mode")

endmodule
